@@ rtl/tia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_pkg
// Telnet command byte codes and option codes used by the negotiator module.
// ----------------------------------------------------------------------------
package tia_pkg;

    localparam logic [7:0] TN_IAC      = 8'hFF;
    localparam logic [7:0] TN_SB       = 8'hFA;
    localparam logic [7:0] TN_SE       = 8'hF0;
    localparam logic [7:0] TN_WILL     = 8'hFB;
    localparam logic [7:0] TN_WONT     = 8'hFC;
    localparam logic [7:0] TN_DO       = 8'hFD;
    localparam logic [7:0] TN_DONT     = 8'hFE;
    localparam logic [7:0] TELOPT_ECHO = 8'h01;
    localparam logic [7:0] TELOPT_SGA  = 8'h03;

    typedef logic [7:0] tn_byte_t;

endpackage

@@ rtl/tia_rx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_rx_if
// Receive byte channel: one telnet byte per word.
// ----------------------------------------------------------------------------
interface tia_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

@@ rtl/tia_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_res_if
// Result channel: data pass-through, negotiation reply and echo flag.
// ----------------------------------------------------------------------------
interface tia_res_if;

    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       reply_valid;
    logic [7:0] reply_command;
    logic [7:0] reply_option;
    logic       server_echo;

    modport source (
        output valid, output data_valid, output data_byte, output reply_valid,
        output reply_command, output reply_option, output server_echo,
        input  ready
    );
    modport sink (
        input  valid, input data_valid, input data_byte, input reply_valid,
        input  reply_command, input reply_option, input server_echo,
        output ready
    );

endinterface

@@ rtl/telnet_iac_negotiator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_iac_negotiator
// Strips telnet IAC sequences from a received byte stream, passes user data
// and produces DO/DONT/WONT replies plus the server echo flag.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | words
//  rx      | in  | rx_byte                                     | 1 per byte
//  res     | out | data_valid data_byte reply_valid             | 1 per rx word
//          |     | reply_command reply_option server_echo      |
//
//  One byte per clock while res.ready is high; a result appears the cycle after
//  its byte is taken, from the single result register behind the parser logic.
//  rx.ready stays high while the result register is empty or being drained;
//  it drops only when a result is held and res.ready is low.
//  rst_n (async, low) returns the parser to normal data and clears the echo
//  flag and the result register.
// ----------------------------------------------------------------------------
module telnet_iac_negotiator (
    input  logic      clk,
    input  logic      rst_n,
    tia_rx_if.sink    rx,
    tia_res_if.source res
);
    import tia_pkg::*;

    typedef enum logic [2:0] {
        ST_NORMAL,
        ST_IAC,
        ST_VERB,
        ST_SUB,
        ST_SUB_IAC
    } parse_state_t;

    parse_state_t state_reg, state_next;
    tn_byte_t     verb_reg, verb_next;
    logic         echo_reg, echo_next;

    logic         out_valid_reg;
    logic         dv_reg, dv_next;
    tn_byte_t     db_reg, db_next;
    logic         rv_reg, rv_next;
    tn_byte_t     rc_reg, rc_next;
    tn_byte_t     ro_reg, ro_next;

    logic         accept;
    tn_byte_t     b;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    always_comb
    begin
        state_next = state_reg;
        verb_next  = verb_reg;
        echo_next  = echo_reg;
        dv_next    = 1'b0;
        rv_next    = 1'b0;
        rc_next    = '0;
        ro_next    = '0;
        unique case (state_reg)
            ST_NORMAL:
            begin
                if (b == TN_IAC)
                    state_next = ST_IAC;
                else
                    dv_next = 1'b1;
            end
            ST_IAC:
            begin
                if (b == TN_IAC)
                begin
                    state_next = ST_NORMAL;
                    dv_next    = 1'b1;
                end
                else if (b == TN_SB)
                    state_next = ST_SUB;
                else if (b == TN_WILL || b == TN_WONT || b == TN_DO || b == TN_DONT)
                begin
                    verb_next  = b;
                    state_next = ST_VERB;
                end
                else
                    state_next = ST_NORMAL;
            end
            ST_VERB:
            begin
                state_next = ST_NORMAL;
                if (verb_reg == TN_WILL)
                begin
                    rv_next = 1'b1;
                    ro_next = b;
                    if (b == TELOPT_ECHO)
                    begin
                        echo_next = 1'b1;
                        rc_next   = TN_DO;
                    end
                    else if (b == TELOPT_SGA)
                        rc_next = TN_DO;
                    else
                        rc_next = TN_DONT;
                end
                else if (verb_reg == TN_DO)
                begin
                    rv_next = 1'b1;
                    rc_next = TN_WONT;
                    ro_next = b;
                end
                else if (verb_reg == TN_WONT && b == TELOPT_ECHO)
                    echo_next = 1'b0;
            end
            ST_SUB:
            begin
                if (b == TN_IAC)
                    state_next = ST_SUB_IAC;
            end
            ST_SUB_IAC:
            begin
                state_next = (b == TN_SE) ? ST_NORMAL : ST_SUB;
            end
            default:
            begin
                state_next = ST_NORMAL;
            end
        endcase
        db_next = dv_next ? b : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NORMAL;
            verb_reg      <= '0;
            echo_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dv_reg        <= 1'b0;
            db_reg        <= '0;
            rv_reg        <= 1'b0;
            rc_reg        <= '0;
            ro_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                verb_reg      <= verb_next;
                echo_reg      <= echo_next;
                out_valid_reg <= 1'b1;
                dv_reg        <= dv_next;
                db_reg        <= db_next;
                rv_reg        <= rv_next;
                rc_reg        <= rc_next;
                ro_reg        <= ro_next;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.data_valid    = dv_reg;
    assign res.data_byte     = db_reg;
    assign res.reply_valid   = rv_reg;
    assign res.reply_command = rc_reg;
    assign res.reply_option  = ro_reg;
    assign res.server_echo   = echo_reg;

`ifndef NO_ASSERTIONS
    // a byte is either data or part of a command, never both
    a_data_xor_reply: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.data_valid && res.reply_valid))
        else $error("data and reply flagged in one word");

    a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.reply_valid) |->
            (res.reply_command == TN_DO || res.reply_command == TN_DONT ||
             res.reply_command == TN_WONT))
        else $error("reply command not DO/DONT/WONT");

    a_echo_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(echo_reg))
        else $error("echo flag changed without an rx word");

    // held result must back-pressure the receive side
    a_stall_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !rx.ready)
        else $error("rx taken while result register is stalled");
`endif

endmodule
